### rtl/hpt_pkg.sv
// Shared types and constants for the histogram percentile threshold unit.
// No dependencies; all files of the block but hpt_checker import it.
package hpt_pkg;

  localparam int RATIO_W    = 17;
  localparam int STRIDE_W   = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_BITS  = 16;

  localparam logic [RATIO_W-1:0]  RATIO_ONE    = 17'h10000;
  localparam logic [RATIO_W-1:0]  RATIO_RESET  = 17'd21627;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd1;

  typedef enum logic {
    REG_RATIO  = 1'b0,
    REG_STRIDE = 1'b1
  } hpt_reg_t;

  typedef struct packed {
    logic pix_take;
    logic scan_start;
    logic scan_issue;
    logic finish;
  } hpt_cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic out_free;
  } hpt_status_t;

endpackage

### rtl/histogram_percentile_threshold_unit.sv
// Top level of the histogram percentile threshold unit.
// Depends on hpt_pkg, hpt_regs, hpt_ctrl and hpt_datapath.
//
// Usage: pixels enter on the input channel (in_valid, in_stall, pixel_value,
// last_pixel), one transfer per cycle while in_stall is low. Every
// sample_stride-th pixel is counted into a histogram held in an on-chip memory
// with a two-stage read-modify-write pipeline.
// After the transfer that carries last_pixel, in_stall rises. The drain state
// computes the cutoff, then the bins are read one per memory cycle from bin 0
// until the running total reaches the cutoff or the last bin is read. The
// threshold is then loaded into the output register (out_valid, out_stall,
// threshold), the histogram is cleared through its valid bits, and in_stall
// falls. A stalled result holds its value; if the previous result is still
// waiting when a scan ends, the block holds in_stall high until the output
// register frees. Reset is synchronous and clears the histogram, counters and
// output; the ratio returns to 21627 (0.33 in Q1.16) and the stride to 1.
// The user must write configuration through the APB-style port only while
// idle; the block itself does not enforce this.
module histogram_percentile_threshold_unit #(
  parameter int PIXEL_BITS      = 8,
  parameter int MAX_PIXELS_LOG2 = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [PIXEL_BITS-1:0]             pixel_value,
  input  logic                              last_pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [PIXEL_BITS-1:0]             threshold,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hpt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [hpt_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [hpt_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import hpt_pkg::*;

  logic [RATIO_W-1:0]  ratio_fraction;
  logic [STRIDE_W-1:0] sample_stride;
  hpt_cmd_t            cmd;
  hpt_status_t         status;

  hpt_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .ratio_fraction (ratio_fraction),
    .sample_stride  (sample_stride)
  );

  hpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_pixel (last_pixel),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  hpt_datapath #(
    .PIXEL_BITS      (PIXEL_BITS),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .pixel_value    (pixel_value),
    .ratio_fraction (ratio_fraction),
    .sample_stride  (sample_stride),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .threshold      (threshold)
  );

endmodule

### rtl/hpt_regs.sv
// Configuration registers behind the APB-style port: ratio and sample stride.
// Depends on hpt_pkg.
module hpt_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hpt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [hpt_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [hpt_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [hpt_pkg::RATIO_W-1:0]       ratio_fraction,
  output logic [hpt_pkg::STRIDE_W-1:0]      sample_stride
);
  import hpt_pkg::*;

  hpt_reg_t sel;
  logic     wr_en;

  assign sel    = hpt_reg_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_fraction <= RATIO_RESET;
      sample_stride  <= STRIDE_RESET;
    end else if (wr_en) begin
      unique case (sel)
        REG_RATIO:  ratio_fraction <= pwdata[RATIO_W-1:0];
        REG_STRIDE: sample_stride  <= pwdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_RATIO:  prdata = {{(CFG_DATA_W-RATIO_W){1'b0}}, ratio_fraction};
      REG_STRIDE: prdata = {{(CFG_DATA_W-STRIDE_W){1'b0}}, sample_stride};
      default:    prdata = '0;
    endcase
  end

endmodule

### rtl/hpt_ctrl.sv
// Controller of the threshold unit: pixel intake, drain, bin scan, result hand-off.
// Depends on hpt_pkg; drives the datapath through hpt_cmd_t.
module hpt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 last_pixel,
  output logic                 in_stall,
  input  hpt_pkg::hpt_status_t status,
  output hpt_pkg::hpt_cmd_t    cmd
);
  import hpt_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  always_comb begin
    cmd            = '0;
    cmd.pix_take   = (state == ST_RUN) && in_valid && !in_stall;
    cmd.scan_start = (state == ST_DRAIN);
    cmd.scan_issue = (state == ST_SCAN);
    cmd.finish     = (state == ST_DONE) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RUN;
      in_stall <= 1'b0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (cmd.pix_take && last_pixel) begin
            state    <= ST_DRAIN;
            in_stall <= 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (status.scan_hit) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (status.out_free) begin
            state    <= ST_RUN;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= ST_RUN;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/hpt_datapath.sv
// Datapath: histogram memory with read-modify-write pipeline, stride and group
// counters, cutoff multiplier, prefix-sum scan and output register. Uses hpt_pkg.
module hpt_datapath #(
  parameter int PIXEL_BITS      = 8,
  parameter int MAX_PIXELS_LOG2 = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  hpt_pkg::hpt_cmd_t            cmd,
  output hpt_pkg::hpt_status_t         status,
  input  logic [PIXEL_BITS-1:0]        pixel_value,
  input  logic [hpt_pkg::RATIO_W-1:0]  ratio_fraction,
  input  logic [hpt_pkg::STRIDE_W-1:0] sample_stride,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [PIXEL_BITS-1:0]        threshold
);
  import hpt_pkg::*;

  localparam int BINS = 1 << PIXEL_BITS;
  localparam int CW   = MAX_PIXELS_LOG2 + 1;
  localparam int TW   = CW + PIXEL_BITS;
  localparam int PW   = CW + RATIO_W;
  localparam logic [CW-1:0]         CNT_MAX  = {CW{1'b1}};
  localparam logic [PIXEL_BITS-1:0] BIN_LAST = {PIXEL_BITS{1'b1}};

  logic [CW-1:0]         mem [BINS];
  logic [BINS-1:0]       vld;

  logic [STRIDE_W-1:0]   stride_pos;
  logic [STRIDE_W-1:0]   stride_eff;
  logic [STRIDE_W:0]     pos_inc;
  logic                  wrap;
  logic [CW-1:0]         group_count;

  logic [PIXEL_BITS-1:0] rd_addr;
  logic [CW-1:0]         rd_data;
  logic                  rd_vld;
  logic [CW-1:0]         bin_val;

  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_addr;
  logic                  wr_valid_q;
  logic [PIXEL_BITS-1:0] wr_addr_q;
  logic [CW-1:0]         wr_data_q;
  logic [CW-1:0]         cur;
  logic [CW-1:0]         wr_data;

  logic [RATIO_W-1:0]    ratio_c;
  logic [PW-1:0]         product;
  logic [CW-1:0]         cutoff;
  logic [PIXEL_BITS-1:0] scan_addr;
  logic                  scan_dv;
  logic [PIXEL_BITS-1:0] scan_da;
  logic [TW-1:0]         total;
  logic [TW-1:0]         sum;
  logic                  hit;
  logic [PIXEL_BITS-1:0] result;

  assign stride_eff = (sample_stride == '0) ? STRIDE_W'(1) : sample_stride;
  assign pos_inc    = {1'b0, stride_pos} + (STRIDE_W+1)'(1);
  assign wrap       = pos_inc >= {1'b0, stride_eff};

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      stride_pos  <= '0;
      group_count <= '0;
    end else if (cmd.pix_take) begin
      stride_pos <= wrap ? '0 : pos_inc[STRIDE_W-1:0];
      if (wrap && group_count != CNT_MAX) begin
        group_count <= group_count + CW'(1);
      end
    end
  end

  // Histogram memory: one registered read, one write per cycle.
  assign rd_addr = cmd.scan_issue ? scan_addr : pixel_value;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
    if (s1_valid) begin
      mem[s1_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      vld <= '0;
    end else if (s1_valid) begin
      vld[s1_addr] <= 1'b1;
    end
  end

  assign bin_val = rd_vld ? rd_data : '0;
  assign cur     = (wr_valid_q && wr_addr_q == s1_addr) ? wr_data_q : bin_val;
  assign wr_data = (cur == CNT_MAX) ? cur : cur + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      wr_valid_q <= 1'b0;
    end else begin
      s1_valid   <= cmd.pix_take && (stride_pos == '0);
      wr_valid_q <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr   <= pixel_value;
    wr_addr_q <= s1_addr;
    wr_data_q <= wr_data;
  end

  // Cutoff and prefix-sum scan over the bins.
  assign ratio_c = (ratio_fraction > RATIO_ONE) ? RATIO_ONE : ratio_fraction;
  assign product = PW'(group_count) * PW'(ratio_c);
  assign sum     = total + TW'(bin_val);
  assign hit     = scan_dv && ((sum >= TW'(cutoff)) || (scan_da == BIN_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_dv <= 1'b0;
    end else begin
      scan_dv <= cmd.scan_issue && !hit;
    end
  end

  always_ff @(posedge clk) begin
    scan_da <= scan_addr;
    if (cmd.scan_start) begin
      cutoff    <= product[FRAC_BITS +: CW];
      scan_addr <= '0;
      total     <= '0;
    end else begin
      if (cmd.scan_issue && scan_addr != BIN_LAST) begin
        scan_addr <= scan_addr + PIXEL_BITS'(1);
      end
      if (scan_dv) begin
        total <= sum;
      end
    end
    if (hit) begin
      result <= scan_da;
    end
  end

  // Output register.
  assign status.scan_hit = hit;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      threshold <= result;
    end
  end

endmodule

### rtl/hpt_checker.sv
// Port-level checker for the threshold unit, bound to the top level.
// Depends only on the ports of histogram_percentile_threshold_unit.
module hpt_checker #(
  parameter int PIXEL_BITS = 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  last_pixel,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [PIXEL_BITS-1:0] threshold
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Block not idle after reset.");

  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_pixel |=> in_stall)
    else $error("Input not stalled after the last pixel transfer.");

  a_result_releases_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall && $past(in_stall))
    else $error("Result appeared without the input being released.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(threshold))
    else $error("Stalled result changed.");

endmodule

bind histogram_percentile_threshold_unit hpt_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_hpt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last_pixel (last_pixel),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .threshold  (threshold)
);
